@@ hw/rtl/bus_address_identity_table_defines.svh @@
// Assertion macros for the port checker file.
`ifndef BUS_ADDRESS_IDENTITY_TABLE_DEFINES_SVH
`define BUS_ADDRESS_IDENTITY_TABLE_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define BAIT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication with next-cycle consequent.
`define BAIT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/bait_pkg.sv @@
// Package with types and constants of the bus address identity table.
package bait_pkg;
	localparam int MaxEntriesDefault = 64;
	localparam int InWidth = 64;
	localparam int OutWidth = 88;
	localparam logic [1:0] KindClaim = 2'd0;
	localparam logic [1:0] KindProduct = 2'd1;
	localparam logic [1:0] IdentSerial = 2'd0;
	localparam logic [1:0] IdentUnique = 2'd1;
	localparam logic [1:0] IdentNone = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RELEASE,
		ST_READ,
		ST_WRITE,
		ST_OUT
	} state_t;

	// One table entry as held in the memory; attached bits live in flops.
	typedef struct packed {
		logic [7:0]  address;
		logic        has_uid;
		logic [31:0] unique_num;
		logic        has_mfg;
		logic [10:0] maker_id;
		logic        has_serial;
		logic [31:0] seen;
	} entry_t;
endpackage

@@ hw/rtl/bus_address_identity_table.sv @@
// Bus address identity table: top level with sequencer and entry memory.
// One item is handled at a time. The sequencer scans the entry memory once,
// one entry a cycle through a registered memory read, matching on both the
// source address and the unique number; a claim that moves a known device
// makes a second pass that detaches other entries at that address. No
// clearing pass is needed: entries beyond the fill count are never read. A
// finished result sits in an output register, and the next transfer is
// accepted only after that result has been taken.
module bus_address_identity_table #(
	parameter int MAX_ENTRIES = bait_pkg::MaxEntriesDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// tdata from bit 0: func, msg_valid, msg_kind[2], src_addr[8], unique flag,
	// unique_number[32], maker flag, maker code[11], serial_present, zero fill
	input  logic [bait_pkg::InWidth-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tdata from bit 0: found, entry_index[6], unique flag,
	// out_unique[32], maker flag, maker code[11], out_has_serial,
	// seen_count[32], ident_kind[2], zero fill
	output logic [bait_pkg::OutWidth-1:0] m_tdata
);
	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	bait_pkg::state_t state_q, state_nx;
	bait_pkg::entry_t mem [MAX_ENTRIES];
	bait_pkg::entry_t rd_s1;
	bait_pkg::entry_t wr_data;
	logic [MAX_ENTRIES-1:0] attached_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;      // address being issued
	logic [IW-1:0] rd_idx_s1;   // index whose data is in rd_s1
	logic          rd_vld_s1;
	logic [IW-1:0] rd_addr;
	logic          mem_we;
	logic [IW-1:0] mem_wa;

	// Captured item.
	logic        func_q, valid_q, has_u_q, has_m_q, ser_q;
	logic [1:0]  kind_q;
	logic [7:0]  addr_q;
	logic [31:0] u_q;
	logic [10:0] mc_q;

	// Scan results.
	logic          hit_a_q, hit_u_q;
	logic [IW-1:0] idx_a_q, idx_u_q;
	logic          rd_has_u_occ;
	logic          d_ok_q;
	logic [IW-1:0] d_q;
	logic          fresh_q;     // entry newly allocated
	logic          sel_ok;
	logic          sel_fresh;
	logic [IW-1:0] sel_d;

	logic [bait_pkg::OutWidth-1:0] out_q;
	logic [bait_pkg::OutWidth-1:0] out_nx;
	logic out_v_q;

	logic scan_done;
	logic in_xfer;
	assign in_xfer = s_tvalid && s_tready;
	assign s_tready = (state_q == bait_pkg::ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;
	assign scan_done = (scan_q >= count_q) && !rd_vld_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= wr_data;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_comb begin
		rd_addr = scan_q[IW-1:0];
		if (state_q == bait_pkg::ST_DECIDE || state_q == bait_pkg::ST_READ) begin
			rd_addr = d_q;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			bait_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_nx = bait_pkg::ST_SCAN;
				end
			end
			bait_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_nx = bait_pkg::ST_DECIDE;
				end
			end
			bait_pkg::ST_DECIDE: begin
				if (!func_q && valid_q && kind_q == bait_pkg::KindClaim && has_u_q
						&& hit_u_q) begin
					state_nx = bait_pkg::ST_RELEASE;
				end else begin
					state_nx = bait_pkg::ST_READ;
				end
			end
			bait_pkg::ST_RELEASE: begin
				if (scan_done) begin
					state_nx = bait_pkg::ST_READ;
				end
			end
			bait_pkg::ST_READ: state_nx = bait_pkg::ST_WRITE;
			bait_pkg::ST_WRITE: state_nx = bait_pkg::ST_OUT;
			bait_pkg::ST_OUT: state_nx = bait_pkg::ST_IDLE;
			default: state_nx = bait_pkg::ST_IDLE;
		endcase
	end

	// Target entry chosen from the scan results.
	always_comb begin
		sel_ok = 1'b0;
		sel_fresh = 1'b0;
		sel_d = idx_a_q;
		if (func_q) begin
			sel_ok = hit_a_q;
		end else if (valid_q) begin
			if (kind_q == bait_pkg::KindClaim && has_u_q && hit_u_q) begin
				sel_ok = 1'b1;
				sel_d = idx_u_q;
			end else if (hit_a_q && !(kind_q == bait_pkg::KindClaim && has_u_q
					&& rd_has_u_occ)) begin
				sel_ok = 1'b1;
			end else if (count_q < CW'(MAX_ENTRIES)) begin
				sel_ok = 1'b1;
				sel_fresh = 1'b1;
				sel_d = count_q[IW-1:0];
			end
		end
	end

	// Modified entry for the write stage.
	always_comb begin
		bait_pkg::entry_t e;
		e = rd_s1;
		if (fresh_q) begin
			e = '0;
			e.address = addr_q;
		end
		if (!func_q && valid_q) begin
			e.address = addr_q;
			if (kind_q == bait_pkg::KindClaim) begin
				if (has_u_q && !hit_u_q) begin
					e.has_uid = 1'b1;
					e.unique_num = u_q;
				end
				if (has_m_q) begin
					e.has_mfg = 1'b1;
					e.maker_id = mc_q;
				end
			end else if (kind_q == bait_pkg::KindProduct && ser_q) begin
				e.has_serial = 1'b1;
			end
			e.seen = e.seen + 32'd1;
		end
		wr_data = e;
	end

	// Result word for the entry as written back.
	always_comb begin
		out_nx = '0;
		out_nx[86:85] = bait_pkg::IdentNone;
		if (d_ok_q) begin
			out_nx[0] = 1'b1;
			out_nx[6:1] = 6'(d_q);
			out_nx[7] = wr_data.has_uid;
			out_nx[39:8] = wr_data.has_uid ? wr_data.unique_num : 32'd0;
			out_nx[40] = wr_data.has_mfg;
			out_nx[51:41] = wr_data.has_mfg ? wr_data.maker_id : 11'd0;
			out_nx[52] = wr_data.has_serial;
			out_nx[84:53] = wr_data.seen;
			out_nx[86:85] = wr_data.has_serial ? bait_pkg::IdentSerial :
				(wr_data.has_uid ? bait_pkg::IdentUnique : bait_pkg::IdentNone);
		end
	end

	assign mem_we = (state_q == bait_pkg::ST_WRITE) && d_ok_q && !func_q && valid_q;
	assign mem_wa = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bait_pkg::ST_IDLE;
			attached_q <= '0;
			count_q <= '0;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			out_v_q <= 1'b0;
			out_q <= '0;
		end else begin
			state_q <= state_nx;
			out_v_q <= (state_q == bait_pkg::ST_OUT) || (out_v_q && !m_tready);
			rd_vld_s1 <= (state_q == bait_pkg::ST_SCAN || state_q == bait_pkg::ST_RELEASE)
				&& (scan_q < count_q);
			unique case (state_q)
				bait_pkg::ST_IDLE: begin
					scan_q <= '0;
				end
				bait_pkg::ST_SCAN, bait_pkg::ST_RELEASE: begin
					if (scan_q < count_q) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rd_vld_s1 && state_q == bait_pkg::ST_RELEASE
							&& rd_idx_s1 != d_q && attached_q[rd_idx_s1]
							&& rd_s1.address == addr_q) begin
						attached_q[rd_idx_s1] <= 1'b0;
					end
				end
				bait_pkg::ST_DECIDE: begin
					scan_q <= '0;
					if (!func_q && valid_q) begin
						if (kind_q == bait_pkg::KindClaim && has_u_q && !hit_u_q
								&& hit_a_q && rd_has_u_occ) begin
							// An occupant with its own unique number is evicted.
							attached_q[idx_a_q] <= 1'b0;
						end
						if (fresh_q) begin
							count_q <= count_q + 1'b1;
						end
						if (d_ok_q) begin
							attached_q[d_q] <= 1'b1;
						end
					end
				end
				bait_pkg::ST_WRITE: begin
					out_q <= out_nx;
				end
				default: ;
			endcase
		end
	end

	// Item capture, scan matching and target selection.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= s_tdata[0];
			valid_q <= s_tdata[1];
			kind_q <= s_tdata[3:2];
			addr_q <= s_tdata[11:4];
			has_u_q <= s_tdata[12];
			u_q <= s_tdata[44:13];
			has_m_q <= s_tdata[45];
			mc_q <= s_tdata[56:46];
			ser_q <= s_tdata[57];
			hit_a_q <= 1'b0;
			hit_u_q <= 1'b0;
			idx_a_q <= '0;
			idx_u_q <= '0;
		end
		rd_idx_s1 <= scan_q[IW-1:0];
		if (state_q == bait_pkg::ST_SCAN && rd_vld_s1) begin
			if (!hit_a_q && attached_q[rd_idx_s1] && rd_s1.address == addr_q) begin
				hit_a_q <= 1'b1;
				idx_a_q <= rd_idx_s1;
			end
			if (!hit_u_q && rd_s1.has_uid && rd_s1.unique_num == u_q) begin
				hit_u_q <= 1'b1;
				idx_u_q <= rd_idx_s1;
			end
		end
		if (state_q == bait_pkg::ST_SCAN && scan_done) begin
			fresh_q <= sel_fresh;
			d_ok_q <= sel_ok;
			d_q <= sel_d;
		end
	end

	// Unique flag of the address occupant, tracked during the scan.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_has_u_occ <= 1'b0;
		end else if (state_q == bait_pkg::ST_SCAN && rd_vld_s1 && !hit_a_q
				&& attached_q[rd_idx_s1] && rd_s1.address == addr_q) begin
			rd_has_u_occ <= rd_s1.has_uid;
		end
	end
endmodule

@@ hw/rtl/bait_checker.sv @@
// Port checker for the bus address identity table and its bind.
`include "bus_address_identity_table_defines.svh"
module bait_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [bait_pkg::OutWidth-1:0] m_tdata
);
	`BAIT_ASSERT(a_busy_after_in, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready, "accepted twice")
	`BAIT_ASSERT(a_no_in_while_out, clk, arst_n, m_tvalid |-> !s_tready, "input taken while result waits")
	`BAIT_ASSERT(a_none_ident, clk, arst_n, (m_tvalid && !m_tdata[0]) |-> (m_tdata[86:85] == bait_pkg::IdentNone), "not found needs ident none")
	`BAIT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
endmodule

bind bus_address_identity_table bait_checker u_bait_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
